// ----- rtl/lie_pkg.sv -----
// ----------------------------------------------------------------------------
// lie_pkg
// Shared types and constants for the indexed list editor.
// ----------------------------------------------------------------------------
package lie_pkg;

   localparam int DATA_W       = 32;
   localparam int CMD_W        = 2;
   localparam int CAPACITY_MAX = 64;
   localparam int CAPACITY_DEF = 64;
   localparam int ADDR_W_MAX   = $clog2(CAPACITY_MAX);

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_BACK  = 2'd1,
      CMD_DELETE     = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_INS_FRONT,
      ST_EMIT_START,
      ST_EMIT_RD,
      ST_EMIT_WR,
      ST_EMIT_EMPTY
   } state_type;

   // store access issued by the sequencer
   typedef struct packed {
      logic                     wr_en;
      logic [ADDR_W_MAX-1:0]    wr_addr;
      logic signed [DATA_W-1:0] wr_data;
      logic [ADDR_W_MAX-1:0]    rd_addr;
   } mem_ctl_type;

   // result beat handed to the output register
   typedef struct packed {
      logic                     load;
      logic signed [DATA_W-1:0] element;
      logic                     is_last;
      logic                     list_empty;
      logic                     insert_refused;
   } out_load_type;

endpackage

// ----- rtl/lie_if.sv -----
// ----------------------------------------------------------------------------
// lie_req_if / lie_rsp_if
// Valid/ready channels for commands and list result beats.
// ----------------------------------------------------------------------------
interface lie_req_if;
   import lie_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         cmd;
   logic signed [DATA_W-1:0] operand;

   modport source (output valid, output cmd, output operand, input ready);
   modport sink   (input valid, input cmd, input operand, output ready);
endinterface

interface lie_rsp_if;
   import lie_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] element;
   logic                     is_last;
   logic                     list_empty;
   logic                     insert_refused;

   modport source (output valid, output element, output is_last, output list_empty,
                   output insert_refused, input ready);
   modport sink   (input valid, input element, input is_last, input list_empty,
                   input insert_refused, output ready);
endinterface

// ----- rtl/indexed_list_editor_core.sv -----
// Throughput: one command at a time; the next is taken once the final beat is loaded,
//   as entries are moved and read one per step through the entry store.
// Reset: synchronous; clears the entry count and control, store contents are not cleared.
// ----------------------------------------------------------------------------
// indexed_list_editor_core
// Bounded ordered list with front/back insert and delete at index; every
// command is answered by the full list, one beat per entry, or by a single empty beat.
// ----------------------------------------------------------------------------
module indexed_list_editor_core #(
   parameter int CAPACITY = lie_pkg::CAPACITY_DEF
) (
   input logic       clock,
   input logic       reset,
   lie_req_if.sink   req_ch,
   lie_rsp_if.source rsp_ch
);
   import lie_pkg::*;

   mem_ctl_type              mem_ctl;
   out_load_type             out_load;
   logic signed [DATA_W-1:0] rd_data;
   logic                     out_free;

   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] element_ff;
   logic                     is_last_ff;
   logic                     list_empty_ff;
   logic                     refused_ff;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   lie_seq #(.CAPACITY(CAPACITY)) u_seq (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .out_free (out_free),
      .rd_data  (rd_data),
      .mem_ctl  (mem_ctl),
      .out_load (out_load)
   );

   lie_store #(.CAPACITY(CAPACITY)) u_store (
      .clock   (clock),
      .ctl     (mem_ctl),
      .rd_data (rd_data)
   );

   // output register decouples the sequencer from the result sink
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load.load) begin
         element_ff    <= out_load.element;
         is_last_ff    <= out_load.is_last;
         list_empty_ff <= out_load.list_empty;
         refused_ff    <= out_load.insert_refused;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.element        = element_ff;
   assign rsp_ch.is_last        = is_last_ff;
   assign rsp_ch.list_empty     = list_empty_ff;
   assign rsp_ch.insert_refused = refused_ff;

endmodule

// ----- rtl/lie_store.sv -----
// ----------------------------------------------------------------------------
// lie_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lie_store #(
   parameter int CAPACITY = lie_pkg::CAPACITY_DEF
) (
   input  logic                             clock,
   input  lie_pkg::mem_ctl_type             ctl,
   output logic signed [lie_pkg::DATA_W-1:0] rd_data
);
   import lie_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic signed [DATA_W-1:0] mem [CAPACITY];
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr[AW-1:0]] <= ctl.wr_data;
      end
      rd_data_ff <= mem[ctl.rd_addr[AW-1:0]];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/lie_seq.sv -----
// ----------------------------------------------------------------------------
// lie_seq
// Command sequencer: shifts entries one at a time through the store using a
// single index step unit, then walks the list out beat by beat.
// ----------------------------------------------------------------------------
module lie_seq #(
   parameter int CAPACITY = lie_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   lie_req_if.sink                           req,
   input  logic                              out_free,
   input  logic signed [lie_pkg::DATA_W-1:0] rd_data,
   output lie_pkg::mem_ctl_type              mem_ctl,
   output lie_pkg::out_load_type             out_load
);
   import lie_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic                     front_ff, front_in;
   logic                     refused_ff, refused_in;
   logic signed [DATA_W-1:0] opnd_ff, opnd_in;

   logic [CW-1:0] step;
   logic          full;
   logic          del_ok;

   // shared index unit: down for front insert, up for delete and readout
   assign step   = front_ff ? (idx_ff - CW'(1)) : (idx_ff + CW'(1));
   assign full   = (count_ff == CW'(CAPACITY));
   assign del_ok = !req.operand[DATA_W-1] &&
                   (req.operand[DATA_W-2:0] < (DATA_W-1)'(count_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         idx_ff     <= '0;
         front_ff   <= 1'b0;
         refused_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         idx_ff     <= idx_in;
         front_ff   <= front_in;
         refused_ff <= refused_in;
      end
      opnd_ff <= opnd_in;
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      front_in   = front_ff;
      refused_in = refused_ff;
      opnd_in    = opnd_ff;
      req.ready  = 1'b0;
      mem_ctl         = '0;
      mem_ctl.rd_addr = ADDR_W_MAX'(idx_ff[AW-1:0]);
      out_load                = '0;
      out_load.insert_refused = refused_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               opnd_in    = req.operand;
               refused_in = 1'b0;
               state_in   = ST_EMIT_START;
               case (req.cmd)
                  CMD_PUSH_FRONT: begin
                     if (full) begin
                        refused_in = 1'b1;
                     end else begin
                        front_in = 1'b1;
                        idx_in   = count_ff;
                        state_in = ST_MOVE_RD;
                     end
                  end
                  CMD_PUSH_BACK: begin
                     if (full) begin
                        refused_in = 1'b1;
                     end else begin
                        mem_ctl.wr_en   = 1'b1;
                        mem_ctl.wr_addr = ADDR_W_MAX'(count_ff[AW-1:0]);
                        mem_ctl.wr_data = req.operand;
                        count_in        = count_ff + CW'(1);
                     end
                  end
                  CMD_DELETE: begin
                     if (del_ok) begin
                        front_in = 1'b0;
                        idx_in   = req.operand[CW-1:0];
                        state_in = ST_MOVE_RD;
                     end
                  end
                  default: begin
                     state_in = ST_EMIT_START;
                  end
               endcase
            end
         end
         ST_MOVE_RD: begin
            if (front_ff) begin
               if (idx_ff == '0) begin
                  state_in = ST_INS_FRONT;
               end else begin
                  mem_ctl.rd_addr = ADDR_W_MAX'(step[AW-1:0]);
                  state_in        = ST_MOVE_WR;
               end
            end else begin
               if (step >= count_ff) begin
                  count_in = count_ff - CW'(1);
                  state_in = ST_EMIT_START;
               end else begin
                  mem_ctl.rd_addr = ADDR_W_MAX'(step[AW-1:0]);
                  state_in        = ST_MOVE_WR;
               end
            end
         end
         ST_MOVE_WR: begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_addr = ADDR_W_MAX'(idx_ff[AW-1:0]);
            mem_ctl.wr_data = rd_data;
            idx_in          = step;
            state_in        = ST_MOVE_RD;
         end
         ST_INS_FRONT: begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_addr = '0;
            mem_ctl.wr_data = opnd_ff;
            count_in        = count_ff + CW'(1);
            state_in        = ST_EMIT_START;
         end
         ST_EMIT_START: begin
            idx_in   = '0;
            front_in = 1'b0;
            state_in = (count_ff == '0) ? ST_EMIT_EMPTY : ST_EMIT_RD;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_WR;
         end
         ST_EMIT_WR: begin
            // read address stays on idx while the output slot is busy
            if (out_free) begin
               out_load.load    = 1'b1;
               out_load.element = rd_data;
               out_load.is_last = (step == count_ff);
               idx_in           = step;
               state_in         = (step == count_ff) ? ST_IDLE : ST_EMIT_RD;
            end
         end
         ST_EMIT_EMPTY: begin
            if (out_free) begin
               out_load.load       = 1'b1;
               out_load.is_last    = 1'b1;
               out_load.list_empty = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("list count above capacity");

   a_no_write_in_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_RD || state_ff == ST_EMIT_WR || state_ff == ST_EMIT_EMPTY)
      |-> !mem_ctl.wr_en)
      else $error("store written during readout");

   a_last_ends_cmd: assert property (@(posedge clock) disable iff (reset)
      (out_load.load && out_load.is_last) |=> (state_ff == ST_IDLE))
      else $error("final beat did not return to idle");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      out_load.load |-> out_free)
      else $error("beat loaded into busy output register");

endmodule
